// File: hw/rtl/bls_pkg.sv
// shared types and constants of the big-endian load/store unit
package bls_pkg;

	localparam int unsigned MemBytesDefault = 65536;
	localparam int unsigned MemSizeW        = 17;
	localparam logic [16:0] MemSizeReset    = 17'd65536;
	localparam logic [31:0] DevBase         = 32'hFFF0_0000;
	localparam logic [31:0] VectorAddr      = 32'h0000_0180;
	localparam logic [31:0] EpcOffset       = 32'd4;

	localparam int unsigned InDataW  = 104;
	localparam int unsigned OutDataW = 112;
	localparam int unsigned CfgAddrW = 3;

	localparam logic CfgIdxMemSize = 1'b0;

	typedef enum logic [1:0] {
		SZ_BYTE = 2'd0,
		SZ_HALF = 2'd1,
		SZ_WORD = 2'd2,
		SZ_WIDE = 2'd3
	} size_t;

	typedef enum logic [1:0] {
		EXC_NONE    = 2'd0,
		EXC_LD_ADDR = 2'd1,
		EXC_ST_ADDR = 2'd2,
		EXC_BUS     = 2'd3
	} exc_t;

	typedef enum logic {
		CMD_READ  = 1'b0,
		CMD_WRITE = 1'b1
	} cmd_t;

	typedef struct packed {
		logic        we;
		logic        re;
		logic [3:0]  be;
		logic [31:0] wdata;
	} ram_ctl_t;

endpackage

// File: hw/rtl/big_endian_load_store_unit_top.sv
// top level of the big-endian load/store unit with address exceptions
//
// one access item enters on the s_axis channel: s_axis_tuser is the command
// (0 read, 1 write), s_axis_tdata packs size code, address, write data and pc.
// each item yields exactly one result item on m_axis: read data, device flag,
// exception code and the cause, epc and status registers after the access,
// the redirect request to vector 0x180 and the sticky halt flag.
// the ram read port is addressed at accept; its registered word is aligned in
// the read stage and then captured in the output register.
// throughput is one item per cycle unless the receiver stalls, set by the single
// ram port; aligned writes and reads touch one word each, so no read-modify-write.
// the result sits in an output register; while the receiver stalls, one more
// item is taken into the read stage, then s_axis_tready drops.
// reset clears cause, epc, status and halt, sets mem_size to 65536 and
// empties the pipeline; ram contents are undefined until written.
// mem_size is written through the apb port at byte address 0.
module big_endian_load_store_unit_top #(
	parameter int unsigned MEM_BYTES = bls_pkg::MemBytesDefault
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// apb configuration
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [bls_pkg::CfgAddrW-1:0]   paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	// access items
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// size_code[1:0], address[33:2], write_data[65:34], current_pc[97:66], zero pad
	input  logic [bls_pkg::InDataW-1:0]    s_axis_tdata,
	// command[0]
	input  logic                           s_axis_tuser,
	// result items
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// read_data[31:0], device_access[32], exception_code[34:33], cause_value[40:35],
	// exception_pc[72:41], status_value[104:73], redirect[105], halted[106], zero pad
	output logic [bls_pkg::OutDataW-1:0]   m_axis_tdata
);

	localparam int unsigned Depth = (MEM_BYTES + 3) / 4;
	localparam int unsigned Aw    = (Depth > 1) ? $clog2(Depth) : 1;
	localparam logic [32:0] MemBytesL = 33'(MEM_BYTES);

	// configuration
	logic [bls_pkg::MemSizeW-1:0] mem_size_q;
	logic [32:0]                  limit_q;
	logic                         cfg_wr;
	logic [32:0]                  new_limit;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == bls_pkg::CfgIdxMemSize);
	assign prdata = (paddr[2] == bls_pkg::CfgIdxMemSize) ?
		{{(32-bls_pkg::MemSizeW){1'b0}}, mem_size_q} : 32'd0;
	assign new_limit = ({16'd0, pwdata[16:0]} < MemBytesL) ? {16'd0, pwdata[16:0]} : MemBytesL;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_size_q <= bls_pkg::MemSizeReset;
			limit_q    <= ({16'd0, bls_pkg::MemSizeReset} < MemBytesL) ?
				{16'd0, bls_pkg::MemSizeReset} : MemBytesL;
		end else if (cfg_wr) begin
			mem_size_q <= pwdata[16:0];
			limit_q    <= new_limit;
		end
	end

	// input fields
	bls_pkg::cmd_t  cmd;
	bls_pkg::size_t sz;
	logic [31:0]    addr;
	logic [31:0]    wdata;
	logic [31:0]    pc;

	assign cmd   = bls_pkg::cmd_t'(s_axis_tuser);
	assign sz    = bls_pkg::size_t'(s_axis_tdata[1:0]);
	assign addr  = s_axis_tdata[33:2];
	assign wdata = s_axis_tdata[65:34];
	assign pc    = s_axis_tdata[97:66];

	// pipeline control
	logic v_s1;
	logic adv_s1;
	logic acc;

	assign adv_s1        = v_s1 && (!m_axis_tvalid || m_axis_tready);
	assign s_axis_tready = !v_s1 || adv_s1;
	assign acc           = s_axis_tvalid && s_axis_tready;

	// access checks
	logic [2:0]        nbytes;
	logic [1:0]        amask;
	logic              dev_c;
	logic              mis_c;
	logic              oob_c;
	bls_pkg::exc_t     exc_c;
	logic              do_mem;
	logic [32:0]       end_addr;

	always_comb begin
		unique case (sz)
			bls_pkg::SZ_BYTE: nbytes = 3'd1;
			bls_pkg::SZ_HALF: nbytes = 3'd2;
			default:          nbytes = 3'd4;
		endcase
		amask    = 2'(nbytes - 3'd1);
		end_addr = {1'b0, addr} + {30'd0, nbytes};
		dev_c    = (addr >= bls_pkg::DevBase);
		mis_c    = (addr[1:0] & amask) != 2'd0;
		oob_c    = end_addr > limit_q;
		priority if (dev_c) begin
			exc_c = bls_pkg::EXC_NONE;
		end else if (mis_c) begin
			exc_c = (cmd == bls_pkg::CMD_WRITE) ? bls_pkg::EXC_ST_ADDR : bls_pkg::EXC_LD_ADDR;
		end else if (oob_c) begin
			exc_c = bls_pkg::EXC_BUS;
		end else begin
			exc_c = bls_pkg::EXC_NONE;
		end
		do_mem = !dev_c && !mis_c && !oob_c;
	end

	// ram port
	bls_pkg::ram_ctl_t ram_ctl;
	logic [31:0]       ram_rdata;

	always_comb begin
		ram_ctl.we = acc && do_mem && (cmd == bls_pkg::CMD_WRITE);
		ram_ctl.re = acc && do_mem && (cmd == bls_pkg::CMD_READ);
		unique case (sz)
			bls_pkg::SZ_BYTE: begin
				ram_ctl.be    = 4'b1000 >> addr[1:0];
				ram_ctl.wdata = {4{wdata[7:0]}};
			end
			bls_pkg::SZ_HALF: begin
				ram_ctl.be    = addr[1] ? 4'b0011 : 4'b1100;
				ram_ctl.wdata = {2{wdata[15:0]}};
			end
			default: begin
				ram_ctl.be    = 4'b1111;
				ram_ctl.wdata = wdata;
			end
		endcase
	end

	bls_ram #(
		.DEPTH(Depth),
		.AW   (Aw)
	) u_ram (
		.clk  (clk),
		.ctl  (ram_ctl),
		.addr (addr[Aw+1:2]),
		.rdata(ram_rdata)
	);

	// exception registers
	logic [5:0]  cause_q;
	logic [31:0] epc_q;
	logic [31:0] status_q;
	logic        halted_q;
	logic [5:0]  cause_n;
	logic [31:0] epc_n;
	logic [31:0] status_n;
	logic        halted_n;

	always_comb begin
		cause_n  = cause_q;
		epc_n    = epc_q;
		status_n = status_q;
		halted_n = halted_q;
		if (exc_c != bls_pkg::EXC_NONE) begin
			cause_n  = {2'b00, exc_c, 2'b00};
			epc_n    = pc - bls_pkg::EpcOffset;
			status_n = {status_q[31:6], status_q[3:0], 2'b00};
			halted_n = halted_q || (exc_c == bls_pkg::EXC_BUS);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cause_q  <= '0;
			epc_q    <= '0;
			status_q <= '0;
			halted_q <= 1'b0;
		end else if (acc) begin
			cause_q  <= cause_n;
			epc_q    <= epc_n;
			status_q <= status_n;
			halted_q <= halted_n;
		end
	end

	// read stage
	logic           rd_s1;
	bls_pkg::size_t sz_s1;
	logic [1:0]     off_s1;
	logic           dev_s1;
	bls_pkg::exc_t  exc_s1;
	logic [5:0]     cause_s1;
	logic [31:0]    epc_s1;
	logic [31:0]    status_s1;
	logic           halted_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (acc) begin
			v_s1 <= 1'b1;
		end else if (adv_s1) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			rd_s1     <= do_mem && (cmd == bls_pkg::CMD_READ);
			sz_s1     <= sz;
			off_s1    <= addr[1:0];
			dev_s1    <= dev_c;
			exc_s1    <= exc_c;
			cause_s1  <= cause_n;
			epc_s1    <= epc_n;
			status_s1 <= status_n;
			halted_s1 <= halted_n;
		end
	end

	logic [31:0] rdata_c;

	always_comb begin
		unique case (sz_s1)
			bls_pkg::SZ_BYTE: rdata_c = {24'd0, 8'(ram_rdata >> {~off_s1, 3'b000})};
			bls_pkg::SZ_HALF: rdata_c = {16'd0, off_s1[1] ? ram_rdata[15:0] : ram_rdata[31:16]};
			default:          rdata_c = ram_rdata;
		endcase
		if (!rd_s1) begin
			rdata_c = 32'd0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (adv_s1) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			m_axis_tdata <= {5'd0, halted_s1, (exc_s1 != bls_pkg::EXC_NONE), status_s1, epc_s1,
				cause_s1, exc_s1, dev_s1, rdata_c};
		end
	end

	// checks
	a_dev_no_exc: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && dev_c) |=> (exc_s1 == bls_pkg::EXC_NONE))
		else $error("device access raised an exception");

	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> halted_q)
		else $error("halt flag cleared");

	a_bus_halts: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && exc_c == bls_pkg::EXC_BUS) |=> (halted_q && halted_s1))
		else $error("bus error did not halt");

	a_adv_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> m_axis_tvalid)
		else $error("item lost between read stage and output");

	a_no_mem_on_exc: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_ctl.we || ram_ctl.re) |-> (acc && exc_c == bls_pkg::EXC_NONE && !dev_c))
		else $error("ram accessed by a faulting or device item");

endmodule

// File: hw/rtl/bls_ram.sv
// word-wide synchronous ram with byte-lane write enables and registered read
module bls_ram #(
	parameter int unsigned DEPTH = bls_pkg::MemBytesDefault / 4,
	parameter int unsigned AW    = $clog2(DEPTH)
) (
	input  logic                clk,
	input  bls_pkg::ram_ctl_t   ctl,
	input  logic [AW-1:0]       addr,
	output logic [31:0]         rdata
);

	logic [31:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			if (ctl.we && ctl.be[i]) begin
				mem[addr][8*i +: 8] <= ctl.wdata[8*i +: 8];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.re) begin
			rdata <= mem[addr];
		end
	end

endmodule
